// ===== sv/rhss_pkg.sv =====
// Shared types, constants and helper functions for the header slot scorer.
// No dependencies; every other file of the block imports this package.
package rhss_pkg;

    localparam int unsigned SLOT_W  = 3;
    localparam int unsigned SCORE_W = 5;
    localparam int unsigned ADDR_W  = 23;

    localparam logic [SLOT_W-1:0] SLOT_FIRST       = 3'd0;
    localparam logic [SLOT_W-1:0] SLOT_FIRST_UPPER = 3'd4;
    localparam logic [SLOT_W-1:0] SLOT_LAST        = 3'd5;
    localparam logic [SLOT_W-1:0] SLOT_BEST_RESET  = 3'd2;

    localparam logic [SCORE_W-1:0] SCORE_FLOOR = 5'd1;

    localparam logic [7:0]  LICENSEE_STD    = 8'h33;
    localparam logic [16:0] CHECKSUM_SUM    = 17'h0ffff;
    localparam logic [7:0]  CART_TYPE_LIMIT = 8'h08;
    localparam logic [7:0]  ROM_SIZE_LIMIT  = 8'h10;
    localparam logic [7:0]  RAM_SIZE_LIMIT  = 8'h08;
    localparam logic [7:0]  DEST_LIMIT      = 8'h0e;
    localparam logic [7:0]  DEST_ZERO_MASK  = 8'h4f;
    localparam logic [31:0] GAME_CODE_BSX   = 32'h0000_0100;
    localparam logic [15:0] RESET_VEC_MIN   = 16'h8000;

    localparam logic [7:0] MAP_MASK     = 8'hef;
    localparam logic [7:0] MAP_LOROM    = 8'h20;
    localparam logic [7:0] MAP_HIROM    = 8'h21;
    localparam logic [7:0] MAP_SDD1     = 8'h22;
    localparam logic [7:0] MAP_EXHIROM  = 8'h25;

    localparam logic [ADDR_W-1:0] BASE_LO       = 23'h007fb0;
    localparam logic [ADDR_W-1:0] BASE_HI       = 23'h00ffb0;
    localparam logic [ADDR_W-1:0] BASE_EX       = 23'h40ffb0;
    localparam logic [ADDR_W-1:0] COPIER_OFFSET = 23'h000200;

    typedef struct packed {
        logic [7:0]  licensee;
        logic [15:0] complement_checksum;
        logic [15:0] checksum;
        logic [7:0]  cart_type;
        logic [7:0]  rom_size_code;
        logic [7:0]  ram_size_code;
        logic [7:0]  dest_code;
        logic [31:0] game_code;
        logic [7:0]  map_mode;
        logic [15:0] reset_vector;
        logic [7:0]  reset_opcode;
        logic        slot_readable;
    } t_in_item;

    typedef struct packed {
        logic [SCORE_W-1:0] slot_score;
        logic [SLOT_W-1:0]  best_slot;
        logic [SCORE_W-1:0] best_score;
        logic               copier_header;
        logic [ADDR_W-1:0]  hdr_addr;
        logic               last_slot;
    } t_out_item;

    // Control handed from the input stage to the result stage.
    typedef struct packed {
        logic              load;
        logic [SLOT_W-1:0] slot;
    } t_stage_ctl;

    // Raw file address of each candidate slot.
    function automatic logic [ADDR_W-1:0] slot_address(logic [SLOT_W-1:0] slot);
        logic [ADDR_W-1:0] addr;
        unique case (slot)
            3'd1:    addr = 23'h0101b0;
            3'd2:    addr = 23'h007fb0;
            3'd3:    addr = 23'h0081b0;
            3'd4:    addr = 23'h40ffb0;
            3'd5:    addr = 23'h4101b0;
            default: addr = 23'h00ffb0;
        endcase
        return addr;
    endfunction

    // Slot address less the copier offset on odd slots.
    function automatic logic [ADDR_W-1:0] header_base(logic [SLOT_W-1:0] slot);
        return slot_address(slot) - (slot[0] ? COPIER_OFFSET : '0);
    endfunction

    // Weight of the first instruction at the reset target.
    function automatic logic signed [4:0] opcode_weight(logic [7:0] op, logic relief);
        logic signed [4:0] w;
        unique case (op)
            8'h78, 8'h18, 8'h38, 8'h9c, 8'h4c, 8'h5c:
                w = 5'sd8;
            8'hc2, 8'he2, 8'had, 8'hae, 8'hac, 8'haf,
            8'ha9, 8'ha2, 8'ha0, 8'h20, 8'h22:
                w = 5'sd4;
            8'h40, 8'h60, 8'h6b, 8'hcd, 8'hec, 8'hcc:
                w = relief ? -5'sd2 : -5'sd4;
            8'h00, 8'h02, 8'hdb, 8'h42, 8'hff:
                w = relief ? -5'sd6 : -5'sd8;
            default:
                w = 5'sd0;
        endcase
        return w;
    endfunction

endpackage

// ===== sv/rhss_score.sv =====
// Combinational score of one header slot.
// Depends on rhss_pkg.
module rhss_score (
    input  rhss_pkg::t_in_item                  i_item,
    input  logic [rhss_pkg::SLOT_W-1:0]         i_slot,
    output logic [rhss_pkg::SCORE_W-1:0]        o_score
);
    import rhss_pkg::*;

    logic                 w_bsx;
    logic                 w_kill;
    logic [3:0]           w_hdr;
    logic [2:0]           w_map;
    logic [7:0]           w_mapper;
    logic [7:0]           w_bsxmap;
    logic [ADDR_W-1:0]    w_base;
    logic signed [4:0]    w_weight;
    logic signed [6:0]    w_raw;
    logic signed [6:0]    w_total;

    always_comb begin
        w_bsx    = (i_item.game_code == GAME_CODE_BSX);
        w_kill   = !i_item.slot_readable || (!w_bsx && (i_item.reset_vector < RESET_VEC_MIN));
        w_mapper = i_item.map_mode & MAP_MASK;
        w_bsxmap = i_item.ram_size_code & MAP_MASK;
        w_base   = header_base(i_slot);

        w_hdr = ((i_item.licensee == LICENSEE_STD) ? 4'd2 : 4'd0)
              + ((({1'b0, i_item.complement_checksum} + {1'b0, i_item.checksum})
                  == CHECKSUM_SUM) ? 4'd4 : 4'd0)
              + 4'(i_item.cart_type < CART_TYPE_LIMIT)
              + 4'(i_item.rom_size_code < ROM_SIZE_LIMIT)
              + 4'(i_item.ram_size_code < RAM_SIZE_LIMIT)
              + 4'(i_item.dest_code < DEST_LIMIT)
              + 4'((i_item.dest_code & DEST_ZERO_MASK) == 8'h00)
              + 4'(w_bsx);

        w_map = (((w_base == BASE_LO) && (w_mapper == MAP_LOROM || w_bsxmap == MAP_LOROM))
                    ? 3'd2 : 3'd0)
              + (((w_base == BASE_HI) && (w_mapper == MAP_HIROM || w_bsxmap == MAP_HIROM))
                    ? 3'd2 : 3'd0)
              + (((w_base == BASE_LO) && (w_mapper == MAP_SDD1)) ? 3'd2 : 3'd0)
              + (((w_base == BASE_EX) && (w_mapper == MAP_EXHIROM)) ? 3'd2 : 3'd0);

        w_weight = opcode_weight(i_item.reset_opcode, w_bsx);

        w_raw = signed'({3'b000, w_hdr}) + signed'({4'b0000, w_map})
              + signed'({{2{w_weight[4]}}, w_weight});

        // Upper-area bonus applies to any nonzero score, negative included.
        w_total = ((w_raw != 7'sd0) && (i_slot >= SLOT_FIRST_UPPER)) ? (w_raw + 7'sd4) : w_raw;

        if (w_kill || w_total < 7'sd0) begin
            o_score = '0;
        end else if (w_total > 7'sd31) begin
            o_score = '1;
        end else begin
            o_score = w_total[SCORE_W-1:0];
        end
    end

endmodule

// ===== sv/rhss_select.sv =====
// Running best-slot selection and the result register.
// Depends on rhss_pkg.
module rhss_select (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  rhss_pkg::t_stage_ctl            i_ctl,
    input  logic [rhss_pkg::SCORE_W-1:0]    i_score,
    output rhss_pkg::t_out_item             o_item
);
    import rhss_pkg::*;

    logic [SCORE_W-1:0] r_best_score, n_best_score;
    logic [SLOT_W-1:0]  r_best_slot,  n_best_slot;
    t_out_item          r_item,       n_item;
    logic [SCORE_W-1:0] w_sel_score;
    logic [SLOT_W-1:0]  w_sel_slot;
    logic               w_last;

    always_comb begin
        // Later slot wins ties.
        if (i_score >= r_best_score) begin
            w_sel_score = i_score;
            w_sel_slot  = i_ctl.slot;
        end else begin
            w_sel_score = r_best_score;
            w_sel_slot  = r_best_slot;
        end
        w_last = (i_ctl.slot == SLOT_LAST);

        n_item.slot_score     = i_score;
        n_item.best_slot      = w_sel_slot;
        n_item.best_score     = w_sel_score;
        n_item.copier_header  = w_sel_slot[0];
        n_item.hdr_addr       = header_base(w_sel_slot);
        n_item.last_slot      = w_last;

        n_best_score = r_best_score;
        n_best_slot  = r_best_slot;
        n_item       = i_ctl.load ? n_item : r_item;
        if (i_ctl.load) begin
            // Rearm for the next image after the final slot.
            n_best_score = w_last ? SCORE_FLOOR     : w_sel_score;
            n_best_slot  = w_last ? SLOT_BEST_RESET : w_sel_slot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best_score <= SCORE_FLOOR;
            r_best_slot  <= SLOT_BEST_RESET;
        end else begin
            r_best_score <= n_best_score;
            r_best_slot  <= n_best_slot;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
    end

    assign o_item = r_item;

endmodule

// ===== sv/rom_header_slot_scorer_core.sv =====
// Top level of the cartridge header slot scorer: input stage, slot counter,
// result valid. Depends on rhss_pkg, rhss_score and rhss_select.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+----------------------------
//  in      | into core | i_in_valid / o_in_ready   | i_in_item  (t_in_item)
//  out     | from core | o_out_valid / i_out_ready | o_out_item (t_out_item)
//
// An accepted item goes first into the input register; the score logic and
// best-slot compare then load the result register when it is empty or being
// drained. One item is taken every cycle while the output drains.
// Reset (i_rst_n low, synchronous) empties both stages, zeroes the slot
// counter and rearms the selection at slot 2 with score 1.
// A stall on the output holds the result register and backs up into the
// input stage; o_in_ready drops only when both stages are full.
module rom_header_slot_scorer_core (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  rhss_pkg::t_in_item      i_in_item,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output rhss_pkg::t_out_item     o_out_item
);
    import rhss_pkg::*;

    // Input stage: item plus the slot index it was given on accept.
    logic               r_in_valid, n_in_valid;
    t_in_item           r_in_item;
    logic [SLOT_W-1:0]  r_in_slot;
    logic [SLOT_W-1:0]  r_slot_cnt, n_slot_cnt;
    logic               r_out_valid, n_out_valid;

    logic               w_advance;
    logic               w_accept;
    logic [SCORE_W-1:0] w_score;
    t_stage_ctl         w_ctl;

    always_comb begin
        // Result stage takes a new item when empty or being drained.
        w_advance  = !r_out_valid || i_out_ready;
        o_in_ready = !r_in_valid || w_advance;
        w_accept   = i_in_valid && o_in_ready;

        w_ctl.load = r_in_valid && w_advance;
        w_ctl.slot = r_in_slot;

        n_in_valid  = w_accept || (r_in_valid && !w_advance);
        n_out_valid = w_ctl.load || (r_out_valid && !i_out_ready);

        // Advance the slot on each accepted item; wrap after the last one.
        n_slot_cnt = r_slot_cnt;
        if (w_accept) begin
            n_slot_cnt = (r_slot_cnt >= SLOT_LAST) ? SLOT_FIRST : r_slot_cnt + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_slot_cnt  <= SLOT_FIRST;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
            r_slot_cnt  <= n_slot_cnt;
        end
    end

    // Payload: load on accept, hold otherwise.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_item <= i_in_item;
            r_in_slot <= r_slot_cnt;
        end
    end

    rhss_score u_score (
        .i_item  (r_in_item),
        .i_slot  (r_in_slot),
        .o_score (w_score)
    );

    rhss_select u_select (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_score (w_score),
        .o_item  (o_out_item)
    );

    assign o_out_valid = r_out_valid;

endmodule

// ===== sv/rhss_checker.sv =====
// Port-level checks for the header slot scorer, bound to the top level.
// Depends on rhss_pkg and rom_header_slot_scorer_core.
module rhss_checker (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    o_in_ready,
    input  logic                    o_out_valid,
    input  logic                    i_out_ready,
    input  rhss_pkg::t_out_item     o_out_item
);
    import rhss_pkg::*;

    // Hold a stalled result.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n && o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("stalled result changed");

    // Best score not below the score just seen or floor; best slot in range.
    a_best_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.best_score >= o_out_item.slot_score)
                     && (o_out_item.best_score >= SCORE_FLOOR)
                     && (o_out_item.best_slot <= SLOT_LAST))
        else $error("best score or slot out of range");

    // Copier flag and header address follow the best slot.
    a_addr_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.copier_header == o_out_item.best_slot[0])
                     && (o_out_item.hdr_addr == header_base(o_out_item.best_slot)))
        else $error("header address does not match best slot");

    // Input is never refused while the output is free to drain.
    a_in_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_ready |-> o_in_ready)
        else $error("input stalled with output ready");

endmodule

bind rom_header_slot_scorer_core rhss_checker u_rhss_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);
